// File: hdl/btd_pkg.sv
// Shared types, constants and fixed-point helpers for the trajectory block.
package btd_pkg;

	localparam int BTD_MAX_POINTS = 64;
	localparam logic [39:0] SAT_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [16:0] STEP_MIN = 17'd66;
	localparam logic [16:0] STEP_MAX = 17'd65536;

	typedef enum logic [1:0] {
		REG_GRAVITY = 2'd0,
		REG_DRAG    = 2'd1,
		REG_STEP    = 2'd2,
		REG_RANGE   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_VSQ,
		S_SPD,
		S_DEC,
		S_EMIT,
		S_K,
		S_ACC,
		S_AH,
		S_HALF,
		S_VH,
		S_UPD,
		S_DSQ,
		S_SEG
	} state_t;

	typedef struct packed {
		logic        start;
		logic [39:0] a;
		logic [39:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] n;
	} sqrt_req_t;

	// Q16.16 product: drop 16 fraction bits and saturate at the 40-bit limit.
	function automatic logic [39:0] umulq_fin(input logic [79:0] prod);
		logic [63:0] hi;
		begin
			hi = prod[79:16];
			umulq_fin = (hi > {24'd0, SAT_MAX}) ? SAT_MAX : prod[55:16];
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		begin
			if (v > 43'sd2147483647)
				sat32 = 32'sh7FFF_FFFF;
			else if (v < -43'sd2147483648)
				sat32 = 32'sh8000_0000;
			else
				sat32 = v[31:0];
		end
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		begin
			mag32 = v[31] ? 32'(-v) : 32'(v);
		end
	endfunction

	function automatic logic [39:0] mag41(input logic signed [40:0] v);
		logic [40:0] m;
		begin
			m = v[40] ? 41'(-v) : 41'(v);
			mag41 = m[39:0];
		end
	endfunction

endpackage

// File: hdl/btd_mul.sv
// Shared 40x40 multiplier built from a 40x16 array, accumulating 16-bit slices of b in turn.
module btd_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  btd_pkg::mul_req_t req,
	output logic             done,
	output logic [79:0]      prod
);
	import btd_pkg::*;

	logic [39:0] a_q;
	logic [39:0] b_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [79:0] acc_q;
	logic [15:0] chunk;
	logic [55:0] pp;
	logic [79:0] pp_sh;

	always_comb begin
		case (cnt_q)
			2'd0: chunk = b_q[15:0];
			2'd1: chunk = b_q[31:16];
			default: chunk = {8'd0, b_q[39:32]};
		endcase
		pp = a_q * chunk;
		case (cnt_q)
			2'd0: pp_sh = {24'd0, pp};
			2'd1: pp_sh = {8'd0, pp, 16'd0};
			default: pp_sh = {pp[47:0], 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: hdl/btd_sqrt.sv
// Floor square root of a 64-bit value, one result bit per cycle.
module btd_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  btd_pkg::sqrt_req_t req,
	output logic              done,
	output logic [32:0]       root
);
	import btd_pkg::*;

	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.n;
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[32:0];

endmodule

// File: hdl/ballistic_trajectory_with_drag.sv
// Sequencer and state for drag trajectory integration on a shared multiplier and root unit.
// Each point after the start uses 19 products on the shared 40x16 multiplier and two
// square roots (16 products and one root for a final point that reached the ground or
// the range). A shot gives at most MAX_POINTS words; a stalled word holds the sequencer.
// Throughput: one shot at a time; in_ready is high only while no shot is in work.
// Reset clears the sequencer, control registers and out_valid and loads config defaults;
// the datapath and output word registers are not reset.
module ballistic_trajectory_with_drag #(
	parameter int MAX_POINTS = btd_pkg::BTD_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] launch_vx,
	input  logic signed [31:0] launch_vy,
	input  logic signed [31:0] launch_vz,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic               last_point,
	output logic               truncated
);
	import btd_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [22:0] gravity_q, drag_q;
	logic [16:0] step_q, h_q;
	logic [30:0] range_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [40:0] acc_q [3];
	logic signed [40:0] ah_q, t2_q, vh_q;
	logic [32:0] dm_q [3];
	logic        big_q;
	logic [63:0] sq_q;
	logic [32:0] speed_q;
	logic [39:0] k_q;
	logic [39:0] path_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]  ax_q;
	logic        first_q;
	logic        iss_q;
	logic        em_last_q, em_trunc_q;

	logic        out_valid_q, last_q, trunc_q;
	logic signed [31:0] px_q, py_q, pz_q;

	mul_req_t  mreq;
	sqrt_req_t sreq;
	logic        mul_done, sqrt_done;
	logic [79:0] prod;
	logic [32:0] root;
	logic [39:0] fin;
	logic        out_free;
	logic        mul_state;

	btd_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mul_done), .prod(prod));
	btd_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sreq), .done(sqrt_done), .root(root));

	assign fin = umulq_fin(prod);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Operand selection and start requests for the shared multiplier and root unit.
	always_comb begin
		logic [31:0] m32;
		m32 = big_q ? dm_q[ax_q][32:1] : dm_q[ax_q][31:0];
		mreq.a = '0;
		mreq.b = '0;
		mul_state = 1'b1;
		unique case (state_q)
			S_VSQ: begin
				mreq.a = {8'd0, mag32(vel_q[ax_q])};
				mreq.b = {8'd0, mag32(vel_q[ax_q])};
			end
			S_DSQ: begin
				mreq.a = {8'd0, m32};
				mreq.b = {8'd0, m32};
			end
			S_K: begin
				mreq.a = {17'd0, drag_q};
				mreq.b = {7'd0, speed_q};
			end
			S_ACC: begin
				mreq.a = {8'd0, mag32(vel_q[ax_q])};
				mreq.b = k_q;
			end
			S_AH: begin
				mreq.a = mag41(acc_q[ax_q]);
				mreq.b = {23'd0, h_q};
			end
			S_HALF: begin
				mreq.a = mag41(ah_q);
				mreq.b = {23'd0, h_q};
			end
			S_VH: begin
				mreq.a = {8'd0, mag32(vel_q[ax_q])};
				mreq.b = {23'd0, h_q};
			end
			default: mul_state = 1'b0;
		endcase
		mreq.start = mul_state && !iss_q;
		sreq.start = (state_q == S_SPD || state_q == S_SEG) && !iss_q;
		sreq.n     = sq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHK;
			S_CHK: begin
				if ((!first_q && pos_q[2] <= 32'sd0) || path_q >= {9'd0, range_q})
					state_d = S_EMIT;
				else
					state_d = S_VSQ;
			end
			S_VSQ: if (mul_done && ax_q == 2'd2) state_d = S_SPD;
			S_SPD: if (sqrt_done) state_d = S_DEC;
			S_DEC: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free)
					state_d = em_last_q ? S_IDLE : S_K;
			end
			S_K: if (mul_done) state_d = S_ACC;
			S_ACC: if (mul_done && ax_q == 2'd2) state_d = S_AH;
			S_AH: if (mul_done) state_d = S_HALF;
			S_HALF: if (mul_done) state_d = S_VH;
			S_VH: if (mul_done) state_d = S_UPD;
			S_UPD: state_d = (ax_q == 2'd2) ? S_DSQ : S_AH;
			S_DSQ: if (mul_done && ax_q == 2'd2) state_d = S_SEG;
			S_SEG: if (sqrt_done) state_d = S_CHK;
			default: state_d = S_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= 23'd642252;
			drag_q    <= 23'd0;
			step_q    <= 17'd655;
			range_q   <= 31'd65536;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_GRAVITY: gravity_q <= cfg_data[22:0];
				REG_DRAG:    drag_q    <= cfg_data[22:0];
				REG_STEP:    step_q    <= cfg_data[16:0];
				REG_RANGE:   range_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q       <= 1'b0;
			ax_q        <= 2'd0;
			cnt_q       <= '0;
			first_q     <= 1'b0;
			em_last_q   <= 1'b0;
			em_trunc_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mreq.start || sreq.start)
				iss_q <= 1'b1;
			else if (mul_done || sqrt_done)
				iss_q <= 1'b0;

			if (state_q == S_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= CW'(1);
						first_q <= 1'b1;
					end
				end
				S_CHK: begin
					ax_q       <= 2'd0;
					em_last_q  <= 1'b1;
					em_trunc_q <= 1'b0;
				end
				S_DEC: begin
					em_last_q  <= (speed_q == '0) || (cnt_q >= CW'(MAX_POINTS));
					em_trunc_q <= (speed_q != '0) && (cnt_q >= CW'(MAX_POINTS));
				end
				S_VSQ, S_ACC, S_DSQ: begin
					if (mul_done)
						ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				S_UPD: ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				S_SEG: begin
					if (sqrt_done) begin
						cnt_q   <= cnt_q + CW'(1);
						first_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		logic signed [41:0] accv;
		logic signed [42:0] psum, vsum;
		logic signed [31:0] nxt;
		logic signed [32:0] d;
		logic [39:0]        half;
		logic [33:0]        seg;
		logic [40:0]        ptot;
		accv = '0;
		psum = '0;
		vsum = '0;
		nxt  = '0;
		d    = '0;
		half = '0;
		seg  = '0;
		ptot = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					pos_q[0] <= start_x;
					pos_q[1] <= start_y;
					pos_q[2] <= start_z;
					vel_q[0] <= launch_vx;
					vel_q[1] <= launch_vy;
					vel_q[2] <= launch_vz;
					path_q   <= '0;
					if (step_q < STEP_MIN)
						h_q <= STEP_MIN;
					else if (step_q > STEP_MAX)
						h_q <= STEP_MAX;
					else
						h_q <= step_q;
				end
			end
			S_CHK: sq_q <= '0;
			S_VSQ, S_DSQ: if (mul_done) sq_q <= sq_q + prod[63:0];
			S_SPD: if (sqrt_done) speed_q <= root;
			S_EMIT: begin
				if (out_free) begin
					px_q    <= pos_q[0];
					py_q    <= pos_q[1];
					pz_q    <= pos_q[2];
					last_q  <= em_last_q;
					trunc_q <= em_trunc_q;
				end
			end
			S_K: begin
				// The segment sum starts from zero once the speed root is taken.
				big_q <= 1'b0;
				sq_q  <= '0;
				if (mul_done) k_q <= fin;
			end
			S_ACC: begin
				if (mul_done) begin
					accv = vel_q[ax_q][31] ? $signed({2'b00, fin}) : -$signed({2'b00, fin});
					if (ax_q == 2'd2) begin
						accv = accv - $signed({19'd0, gravity_q});
						if (accv < -$signed({2'b00, SAT_MAX}))
							accv = -$signed({2'b00, SAT_MAX});
					end
					acc_q[ax_q] <= accv[40:0];
				end
			end
			S_AH: begin
				if (mul_done)
					ah_q <= acc_q[ax_q][40] ? -$signed({1'b0, fin}) : $signed({1'b0, fin});
			end
			S_HALF: begin
				if (mul_done) begin
					half = fin >> 1;
					t2_q <= ah_q[40] ? -$signed({1'b0, half}) : $signed({1'b0, half});
				end
			end
			S_VH: begin
				if (mul_done)
					vh_q <= vel_q[ax_q][31] ? -$signed({1'b0, fin}) : $signed({1'b0, fin});
			end
			S_UPD: begin
				psum = 43'(pos_q[ax_q]) + 43'(vh_q) + 43'(t2_q);
				nxt  = sat32(psum);
				vsum = 43'(vel_q[ax_q]) + 43'(ah_q);
				d    = 33'(nxt) - 33'(pos_q[ax_q]);
				dm_q[ax_q]  <= d[32] ? 33'(-d) : 33'(d);
				if (d[32] ? (d < -33'sd2147483647) : (d > 33'sd2147483647))
					big_q <= 1'b1;
				pos_q[ax_q] <= nxt;
				vel_q[ax_q] <= sat32(vsum);
			end
			S_SEG: begin
				if (sqrt_done) begin
					seg  = big_q ? {root, 1'b0} : {1'b0, root};
					ptot = {1'b0, path_q} + {7'd0, seg};
					path_q <= (ptot > {1'b0, SAT_MAX}) ? SAT_MAX : ptot[39:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign point_x    = px_q;
	assign point_y    = py_q;
	assign point_z    = pz_q;
	assign last_point = last_q;
	assign truncated  = trunc_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && sqrt_done))
		else $error("multiplier and root unit finished together");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count beyond cap");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!trunc_q || last_q))
		else $error("truncated word not marked last");

	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CHK))
		else $error("accepted shot did not start checking");

endmodule
